/* rtl/core/nec_ir_pulse_decoder_assert.svh */
// Assertion macros for the NEC IR decoder RTL.
`ifndef NEC_IR_PULSE_DECODER_ASSERT_SVH
`define NEC_IR_PULSE_DECODER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define NIP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define NIP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/nip_pkg.sv */
// Package for the NEC IR pulse decoder: codes, defaults and shared types.
package nip_pkg;

   localparam int unsigned FRAME_BITS       = 32;
   localparam int unsigned LATCH_US_DEFAULT = 300000;
   localparam int unsigned NUM_CFG          = 8;
   localparam int unsigned CFG_IDX_W        = 3;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_LEAD_MARK_MIN   = 3'd0,
      CSR_LEAD_MARK_MAX   = 3'd1,
      CSR_LEAD_SPACE_MIN  = 3'd2,
      CSR_LEAD_SPACE_MAX  = 3'd3,
      CSR_SHORT_PULSE_MIN = 3'd4,
      CSR_SHORT_PULSE_MAX = 3'd5,
      CSR_ONE_SPACE_MIN   = 3'd6,
      CSR_ONE_SPACE_MAX   = 3'd7
   } csr_index_type;

   localparam logic [15:0] CFG_DEFAULT [NUM_CFG] = '{
      16'd8500, 16'd9500, 16'd4000, 16'd5000, 16'd400, 16'd700, 16'd1500, 16'd1900
   };

   typedef enum logic {
      CMD_EDGE = 1'b0,
      CMD_POLL = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_LEAD_LOW  = 3'd1,
      PH_LEAD_HIGH = 3'd2,
      PH_DATA_LOW  = 3'd3,
      PH_DATA_HIGH = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FRAME = 2'd1,
      ST_EDGE  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] lead_mark_min;
      logic [15:0] lead_mark_max;
      logic [15:0] lead_space_min;
      logic [15:0] lead_space_max;
      logic [15:0] short_pulse_min;
      logic [15:0] short_pulse_max;
      logic [15:0] one_space_min;
      logic [15:0] one_space_max;
   } bounds_type;

   typedef struct packed {
      status_type  rx_status;
      logic [15:0] frame_word;
      logic        frame_new;
      logic [15:0] pulse_width;
      logic [15:0] edge_total;
   } result_type;

endpackage

/* rtl/core/nip_cfg_regs.sv */
// Window bound registers with zero-selects-default resolution.
module nip_cfg_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [nip_pkg::CFG_IDX_W-1:0]        csr_index,
   input  logic [15:0]                          csr_wdata,
   output nip_pkg::bounds_type                  bounds
);
   import nip_pkg::*;

   logic [15:0] cfg_ff [NUM_CFG];
   logic [15:0] res    [NUM_CFG];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) begin
            cfg_ff[i] <= CFG_DEFAULT[i];
         end
      end else if (csr_write_en) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // zero in a register selects the window's default
   always_comb begin
      for (int i = 0; i < NUM_CFG; i++) begin
         res[i] = (cfg_ff[i] != 16'd0) ? cfg_ff[i] : CFG_DEFAULT[i];
      end
   end

   assign bounds.lead_mark_min   = res[CSR_LEAD_MARK_MIN];
   assign bounds.lead_mark_max   = res[CSR_LEAD_MARK_MAX];
   assign bounds.lead_space_min  = res[CSR_LEAD_SPACE_MIN];
   assign bounds.lead_space_max  = res[CSR_LEAD_SPACE_MAX];
   assign bounds.short_pulse_min = res[CSR_SHORT_PULSE_MIN];
   assign bounds.short_pulse_max = res[CSR_SHORT_PULSE_MAX];
   assign bounds.one_space_min   = res[CSR_ONE_SPACE_MIN];
   assign bounds.one_space_max   = res[CSR_ONE_SPACE_MAX];

endmodule

/* rtl/core/nip_decode.sv */
// Decoder state and single-pass edge/poll update logic.
module nip_decode #(
   parameter int unsigned LATCH_US = nip_pkg::LATCH_US_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  nip_pkg::cmd_type    cmd,
   input  logic                line_level,
   input  logic [31:0]         time_us,
   input  nip_pkg::bounds_type bounds,
   output nip_pkg::result_type result
);
   import nip_pkg::*;

   localparam logic [31:0] LatchLim = 32'(LATCH_US);

   phase_type   phase_ff,  phase_in;
   logic [31:0] fall_ff,   fall_in;
   logic [31:0] rise_ff,   rise_in;
   logic [31:0] shift_ff,  shift_in;
   logic [5:0]  count_ff,  count_in;
   logic [31:0] event_ff,  event_in;
   status_type  status_ff, status_in;
   logic [15:0] frame_ff,  frame_in;
   logic [15:0] pulse_ff,  pulse_in;
   logic [15:0] edges_ff,  edges_in;
   logic        fresh;
   logic        bit_ok;
   logic [31:0] width;
   logic [31:0] elapsed;

   function automatic logic in_window(logic [31:0] w, logic [15:0] lo, logic [15:0] hi);
      return (w[31:16] == 16'd0) && (w[15:0] >= lo) && (w[15:0] <= hi);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         fall_ff   <= '0;
         rise_ff   <= '0;
         shift_ff  <= '0;
         count_ff  <= '0;
         event_ff  <= '0;
         status_ff <= ST_IDLE;
         frame_ff  <= '0;
         pulse_ff  <= '0;
         edges_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         fall_ff   <= fall_in;
         rise_ff   <= rise_in;
         shift_ff  <= shift_in;
         count_ff  <= count_in;
         event_ff  <= event_in;
         status_ff <= status_in;
         frame_ff  <= frame_in;
         pulse_ff  <= pulse_in;
         edges_ff  <= edges_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      fall_in   = fall_ff;
      rise_in   = rise_ff;
      shift_in  = shift_ff;
      count_in  = count_ff;
      event_in  = event_ff;
      status_in = status_ff;
      frame_in  = frame_ff;
      pulse_in  = pulse_ff;
      edges_in  = edges_ff;
      fresh     = 1'b0;
      bit_ok    = 1'b1;
      elapsed   = time_us - event_ff;
      width     = line_level ? (time_us - fall_ff) : (time_us - rise_ff);

      if (step) begin
         if (cmd == CMD_POLL) begin
            // drop to idle once the latch time has run out
            if (status_ff != ST_IDLE && elapsed > LatchLim) begin
               status_in = ST_IDLE;
            end
         end else begin
            edges_in  = edges_ff + 16'd1;
            status_in = ST_EDGE;
            event_in  = time_us;
            pulse_in  = (width[31:16] != 16'd0) ? 16'hFFFF : width[15:0];
            if (!line_level) begin
               fall_in = time_us;
               unique case (phase_ff)
                  PH_IDLE: begin
                     phase_in = PH_LEAD_LOW;
                  end
                  PH_LEAD_HIGH: begin
                     phase_in = in_window(width, bounds.lead_space_min,
                                          bounds.lead_space_max) ? PH_DATA_LOW : PH_IDLE;
                     shift_in = '0;
                     count_in = '0;
                  end
                  PH_DATA_HIGH: begin
                     // short window wins where the windows overlap
                     if (in_window(width, bounds.short_pulse_min, bounds.short_pulse_max)) begin
                        count_in = count_ff + 6'd1;
                     end else if (in_window(width, bounds.one_space_min,
                                            bounds.one_space_max)) begin
                        shift_in = shift_ff | (32'd1 << count_ff[4:0]);
                        count_in = count_ff + 6'd1;
                     end else begin
                        bit_ok = 1'b0;
                     end
                     if (!bit_ok) begin
                        phase_in = PH_IDLE;
                        shift_in = '0;
                        count_in = '0;
                     end else if (count_in >= 6'(FRAME_BITS)) begin
                        if ((shift_in[7:0] ^ shift_in[15:8]) == 8'hFF &&
                            (shift_in[23:16] ^ shift_in[31:24]) == 8'hFF) begin
                           frame_in  = {shift_in[7:0], shift_in[23:16]};
                           status_in = ST_FRAME;
                           fresh     = 1'b1;
                        end
                        phase_in = PH_IDLE;
                        shift_in = '0;
                        count_in = '0;
                     end else begin
                        phase_in = PH_DATA_LOW;
                     end
                  end
                  PH_LEAD_LOW, PH_DATA_LOW: begin
                  end
                  default: begin
                  end
               endcase
            end else begin
               rise_in = time_us;
               unique case (phase_ff)
                  PH_LEAD_LOW: begin
                     if (in_window(width, bounds.lead_mark_min, bounds.lead_mark_max)) begin
                        phase_in = PH_LEAD_HIGH;
                     end else begin
                        phase_in = PH_IDLE;
                        shift_in = '0;
                        count_in = '0;
                     end
                  end
                  PH_DATA_LOW: begin
                     if (in_window(width, bounds.short_pulse_min, bounds.short_pulse_max)) begin
                        phase_in = PH_DATA_HIGH;
                     end else begin
                        phase_in = PH_IDLE;
                        shift_in = '0;
                        count_in = '0;
                     end
                  end
                  PH_IDLE, PH_LEAD_HIGH, PH_DATA_HIGH: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      result.rx_status   = status_in;
      result.frame_word  = frame_in;
      result.frame_new   = fresh;
      result.pulse_width = pulse_in;
      result.edge_total  = edges_in;
   end

endmodule

/* rtl/core/nec_ir_pulse_decoder.sv */
// Flow: an accepted request waits in the input register until the response register is free or taken.
// Throughput: one request per cycle while rsp_ready holds; the decoder state updates in one pass
// between the request register and the response register.
// Reset is synchronous and active high: window registers return to their
// defaults, decoder state, counters and status clear, both stages empty.
`include "nec_ir_pulse_decoder_assert.svh"
module nec_ir_pulse_decoder #(
   parameter int unsigned LATCH_US = nip_pkg::LATCH_US_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic                          req_line_level,
   input  logic [31:0]                   req_time_us,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_rx_status,
   output logic [15:0]                   rsp_frame_word,
   output logic                          rsp_frame_new,
   output logic [15:0]                   rsp_pulse_width,
   output logic [15:0]                   rsp_edge_total,
   input  logic                          csr_write_en,
   input  logic [nip_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata
);
   import nip_pkg::*;

   bounds_type  bounds;
   result_type  result;
   result_type  rsp_ff;
   logic        rsp_valid_ff;
   logic        in_valid_ff;
   cmd_type     in_cmd_ff;
   logic        in_level_ff;
   logic [31:0] in_time_ff;
   logic        advance;
   logic        req_fire;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff   <= cmd_type'(req_cmd);
         in_level_ff <= req_line_level;
         in_time_ff  <= req_time_us;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   nip_cfg_regs u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .bounds       (bounds)
   );

   nip_decode #(
      .LATCH_US (LATCH_US)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .cmd        (in_cmd_ff),
      .line_level (in_level_ff),
      .time_us    (in_time_ff),
      .bounds     (bounds),
      .result     (result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rx_status   = rsp_ff.rx_status;
   assign rsp_frame_word  = rsp_ff.frame_word;
   assign rsp_frame_new   = rsp_ff.frame_new;
   assign rsp_pulse_width = rsp_ff.pulse_width;
   assign rsp_edge_total  = rsp_ff.edge_total;

   `NIP_ASSERT_NOW(a_new_frame_status, clock, reset, rsp_valid_ff && rsp_ff.frame_new, rsp_ff.rx_status == ST_FRAME, "new frame without frame status")
   `NIP_ASSERT_NEXT(a_advance_gives_rsp, clock, reset, advance, rsp_valid_ff, "processed request produced no response")
   `NIP_ASSERT_NEXT(a_poll_no_frame, clock, reset, advance && in_cmd_ff == CMD_POLL, !rsp_ff.frame_new, "poll reported a new frame")
   `NIP_ASSERT_NEXT(a_accept_loads, clock, reset, req_fire, in_valid_ff, "accepted request lost from input stage")

endmodule

/* verif/nec_ir_decode_check.sv */
// Decode predictor and response checker for the NEC IR pulse decoder.
module nec_ir_decode_check #(
   parameter int unsigned LATCH_US = nip_pkg::LATCH_US_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_cmd,
   input  logic                          req_line_level,
   input  logic [31:0]                   req_time_us,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_rx_status,
   input  logic [15:0]                   rsp_frame_word,
   input  logic                          rsp_frame_new,
   input  logic [15:0]                   rsp_pulse_width,
   input  logic [15:0]                   rsp_edge_total,
   input  logic                          csr_write_en,
   input  logic [nip_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata,
   output int                            pending,
   output int                            fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import nip_pkg::*;

   logic [15:0] win [NUM_CFG];
   phase_type   phase;
   logic [31:0] fall_at;
   logic [31:0] rise_at;
   logic [31:0] bits_in;
   logic [5:0]  bit_idx;
   logic [31:0] event_at;
   status_type  status;
   logic [15:0] frame;
   logic [15:0] width_seen;
   logic [15:0] edges;
   result_type  decoded_q [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic logic [31:0] bound_of(csr_index_type r);
      return (win[r] != 16'd0) ? {16'd0, win[r]} : {16'd0, CFG_DEFAULT[r]};
   endfunction

   function automatic logic fits(logic [31:0] w, csr_index_type lo, csr_index_type hi);
      return (w >= bound_of(lo)) && (w <= bound_of(hi));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("t=%0t mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
   endtask

   task automatic clear_decoder();
      phase = PH_IDLE;
      bits_in = '0;
      bit_idx = '0;
   endtask

   task automatic decode_request(input logic c, input logic lvl, input logic [31:0] now,
                                 output result_type res);
      logic [31:0] w;
      logic        fresh;
      logic        ok;
      fresh = 1'b0;
      ok = 1'b1;
      if (c == CMD_POLL) begin
         if (status != ST_IDLE && (now - event_at) > LATCH_US)
            status = ST_IDLE;
      end else begin
         edges = edges + 16'd1;
         status = ST_EDGE;
         event_at = now;
         if (lvl == 1'b0) begin
            w = now - rise_at;
            fall_at = now;
            width_seen = (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
            case (phase)
               PH_LEAD_HIGH: begin
                  if (fits(w, CSR_LEAD_SPACE_MIN, CSR_LEAD_SPACE_MAX)) begin
                     phase = PH_DATA_LOW;
                     bits_in = '0;
                     bit_idx = '0;
                  end else begin
                     clear_decoder();
                  end
               end
               PH_DATA_HIGH: begin
                  // short space wins where the windows overlap
                  if (fits(w, CSR_SHORT_PULSE_MIN, CSR_SHORT_PULSE_MAX)) begin
                     bit_idx = bit_idx + 6'd1;
                  end else if (fits(w, CSR_ONE_SPACE_MIN, CSR_ONE_SPACE_MAX)) begin
                     bits_in[bit_idx[4:0]] = 1'b1;
                     bit_idx = bit_idx + 6'd1;
                  end else begin
                     clear_decoder();
                     ok = 1'b0;
                  end
                  if (ok && bit_idx >= FRAME_BITS) begin
                     // drop the frame silently when either inversion byte is wrong
                     if ((bits_in[7:0] ^ bits_in[15:8]) == 8'hFF &&
                         (bits_in[23:16] ^ bits_in[31:24]) == 8'hFF) begin
                        frame = {bits_in[7:0], bits_in[23:16]};
                        status = ST_FRAME;
                        fresh = 1'b1;
                     end
                     clear_decoder();
                  end else if (ok) begin
                     phase = PH_DATA_LOW;
                  end
               end
               PH_IDLE: phase = PH_LEAD_LOW;
               default: ;
            endcase
         end else begin
            w = now - fall_at;
            rise_at = now;
            width_seen = (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
            if (phase == PH_LEAD_LOW) begin
               if (fits(w, CSR_LEAD_MARK_MIN, CSR_LEAD_MARK_MAX)) phase = PH_LEAD_HIGH;
               else clear_decoder();
            end else if (phase == PH_DATA_LOW) begin
               if (fits(w, CSR_SHORT_PULSE_MIN, CSR_SHORT_PULSE_MAX)) phase = PH_DATA_HIGH;
               else clear_decoder();
            end
         end
      end
      res.rx_status = status;
      res.frame_word = frame;
      res.frame_new = fresh;
      res.pulse_width = width_seen;
      res.edge_total = edges;
   endtask

   always @(posedge clock) begin
      result_type want;
      int i;
      if (reset) begin
         for (i = 0; i < NUM_CFG; i++) win[i] = CFG_DEFAULT[i];
         clear_decoder();
         fall_at = '0;
         rise_at = '0;
         event_at = '0;
         status = ST_IDLE;
         frame = '0;
         width_seen = '0;
         edges = '0;
         decoded_q.delete();
      end else begin
         if (csr_write_en) win[csr_index] = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = decoded_q.pop_front();
               check_field("rx_status", want.rx_status, rsp_rx_status);
               check_field("frame_word", want.frame_word, rsp_frame_word);
               check_field("frame_new", want.frame_new, rsp_frame_new);
               check_field("pulse_width", want.pulse_width, rsp_pulse_width);
               check_field("edge_total", want.edge_total, rsp_edge_total);
            end
         end
         if (req_valid && req_ready) begin
            decode_request(req_cmd, req_line_level, req_time_us, want);
            decoded_q.push_back(want);
         end
      end
      pending <= decoded_q.size();
   end

endmodule

/* verif/testbench.sv */
// Top of the NEC IR decoder testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import nip_pkg::*;

   localparam int          FRAME_EDGES = 3 + 2 * FRAME_BITS;
   localparam int          PHASE_ITEMS = 90;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic          req_cmd;
   logic          req_line_level;
   logic [31:0]   req_time_us;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [1:0]    rsp_rx_status;
   logic [15:0]   rsp_frame_word;
   logic          rsp_frame_new;
   logic [15:0]   rsp_pulse_width;
   logic [15:0]   rsp_edge_total;
   logic          csr_write_en;
   csr_index_type csr_index;
   logic [15:0]   csr_wdata;
   int            pending;
   int            fail_count;

   int            send_idle_pct = 0;
   int            rx_stall_pct = 0;
   int            sent = 0;
   int unsigned   cycles = 0;
   logic [31:0]   now = '0;
   logic [31:0]   last_edge = '0;
   logic [15:0]   cur_win [NUM_CFG];

   logic [15:0]   zero_w [NUM_CFG] = '{default: 16'd0};
   logic [15:0]   wide_w [NUM_CFG] = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF,
                                       16'd1, 16'hFFFF, 16'd1, 16'hFFFF};
   logic [15:0]   peak_w [NUM_CFG] = '{default: 16'hFFFF};
   // one-space window inverted, everything else at its default
   logic [15:0]   flip_w [NUM_CFG] = '{16'd0, 16'd0, 16'd0, 16'd0,
                                       16'd0, 16'd0, 16'd1900, 16'd1500};
   logic [15:0]   rand_w [NUM_CFG];

   nec_ir_pulse_decoder u_top (.*);

   nec_ir_decode_check u_check (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** nec_ir_pulse_decoder: FAILED **");
         $finish;
      end
   end

   task automatic send_item(input cmd_type c, input logic lvl, input logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_line_level <= lvl;
      req_time_us <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_edge(input logic lvl, input logic [31:0] delta);
      now = now + delta;
      last_edge = now;
      send_item(CMD_EDGE, lvl, now);
   endtask

   task automatic send_poll(input logic [31:0] t);
      now = t;
      send_item(CMD_POLL, 1'($urandom_range(1, 0)), t);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input csr_index_type r, input logic [15:0] v);
      csr_write_en <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      cur_win[r] = v;
      @(posedge clock);
   endtask

   task automatic load_windows(input logic [15:0] w [NUM_CFG]);
      csr_index_type r;
      r = CSR_LEAD_MARK_MIN;
      repeat (NUM_CFG) begin
         write_window(r, w[r]);
         r = r.next();
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic randomize_windows(input int zero_pct);
      int          p;
      logic [15:0] lo;
      for (p = 0; p < NUM_CFG; p += 2) begin
         lo = 16'($urandom_range(20000, 1));
         rand_w[p] = lo;
         rand_w[p + 1] = lo + 16'($urandom_range(4000, 0));
         if ($urandom_range(99) < zero_pct) rand_w[p] = '0;
         if ($urandom_range(99) < zero_pct) rand_w[p + 1] = '0;
      end
   endtask

   // pick a width the current window accepts, or anything if it is inverted
   function automatic logic [31:0] pick_width(csr_index_type lo_r, csr_index_type hi_r);
      logic [15:0] lo;
      logic [15:0] hi;
      lo = (cur_win[lo_r] != 16'd0) ? cur_win[lo_r] : CFG_DEFAULT[lo_r];
      hi = (cur_win[hi_r] != 16'd0) ? cur_win[hi_r] : CFG_DEFAULT[hi_r];
      if (lo <= hi) return $urandom_range(hi, lo);
      return $urandom_range(65535, 1);
   endfunction

   task automatic send_frame(input logic [31:0] raw, input int bad_at, input int n_edges);
      int          e;
      logic        lvl;
      logic [31:0] delta;
      // long quiet pulses force the decoder back to idle from any phase
      send_edge(1'b1, 32'd100000);
      send_edge(1'b0, 32'd100000);
      send_edge(1'b1, 32'd100000);
      for (e = 0; e < n_edges; e++) begin
         if (e == 0) begin
            lvl = 1'b0;
            delta = $urandom_range(30000, 1);
         end else if (e == 1) begin
            lvl = 1'b1;
            delta = pick_width(CSR_LEAD_MARK_MIN, CSR_LEAD_MARK_MAX);
         end else if (e == 2) begin
            lvl = 1'b0;
            delta = pick_width(CSR_LEAD_SPACE_MIN, CSR_LEAD_SPACE_MAX);
         end else if (e % 2 == 1) begin
            lvl = 1'b1;
            delta = pick_width(CSR_SHORT_PULSE_MIN, CSR_SHORT_PULSE_MAX);
         end else begin
            lvl = 1'b0;
            delta = raw[(e - 4) / 2] ? pick_width(CSR_ONE_SPACE_MIN, CSR_ONE_SPACE_MAX)
                                     : pick_width(CSR_SHORT_PULSE_MIN, CSR_SHORT_PULSE_MAX);
         end
         if (e == bad_at) delta = $urandom_range(70000, 0);
         send_edge(lvl, delta);
      end
      // trailing mark returns the line high
      if (n_edges == FRAME_EDGES)
         send_edge(1'b1, pick_width(CSR_SHORT_PULSE_MIN, CSR_SHORT_PULSE_MAX));
   endtask

   task automatic run_phase(input logic [15:0] w [NUM_CFG], input int idle_pct,
                            input int stall_pct);
      int          stop;
      int          roll;
      logic [7:0]  addr;
      logic [7:0]  code;
      logic [31:0] raw;
      drain();
      load_windows(w);
      send_idle_pct = idle_pct;
      rx_stall_pct = stall_pct;
      stop = sent + PHASE_ITEMS;
      while (sent < stop) begin
         roll = $urandom_range(99);
         addr = 8'($urandom_range(255, 0));
         code = 8'($urandom_range(255, 0));
         raw = {~code, code, ~addr, addr};
         if (roll < 60) begin
            send_frame(raw, -1, FRAME_EDGES);
         end else if (roll < 68) begin
            raw[$urandom_range(31, 0)] ^= 1'b1;
            send_frame(raw, -1, FRAME_EDGES);
         end else if (roll < 76) begin
            send_frame(raw, $urandom_range(FRAME_EDGES - 1, 0), FRAME_EDGES);
         end else if (roll < 82) begin
            send_frame(raw, -1, $urandom_range(FRAME_EDGES - 1, 1));
         end else if (roll < 91) begin
            repeat ($urandom_range(5, 1)) begin
               case ($urandom_range(2, 0))
                  0: send_edge(1'($urandom_range(1, 0)), $urandom_range(2000, 0));
                  1: send_edge(1'($urandom_range(1, 0)), $urandom_range(20000, 0));
                  default: send_edge(1'($urandom_range(1, 0)), $urandom);
               endcase
            end
         end else begin
            repeat ($urandom_range(3, 1)) begin
               case ($urandom_range(3, 0))
                  0: send_poll(now + $urandom_range(1000, 0));
                  1: send_poll(last_edge + LATCH_US_DEFAULT + $urandom_range(1, 0));
                  2: send_poll(now + $urandom);
                  default: send_poll($urandom);
               endcase
            end
         end
         // hold off now and then until every response is back
         if ($urandom_range(9) == 0) drain();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_EDGE;
      req_line_level <= 1'b0;
      req_time_us <= '0;
      rsp_ready <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_LEAD_MARK_MIN;
      csr_wdata <= '0;
      foreach (cur_win[i]) cur_win[i] = CFG_DEFAULT[i];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk through the decoder with default windows
      send_poll(32'd0);
      now = 32'hFFFF_FFF0;
      send_edge(1'b1, 32'd0);
      send_edge(1'b0, 32'h20);
      send_edge(1'b1, 32'd8499);
      send_edge(1'b0, 32'd1000);
      send_edge(1'b1, 32'd8500);
      send_edge(1'b0, 32'd5001);
      send_edge(1'b0, 32'd100);
      send_edge(1'b0, 32'd100);
      send_edge(1'b1, 32'd9500);
      send_edge(1'b1, 32'd50);
      send_edge(1'b0, 32'd4000);
      send_edge(1'b0, 32'd10);
      send_edge(1'b1, 32'd400);
      send_edge(1'b1, 32'd5);
      send_edge(1'b0, 32'd1900);
      send_edge(1'b1, 32'd700);
      send_edge(1'b0, 32'd700);
      send_poll(last_edge + LATCH_US_DEFAULT);
      send_poll(last_edge + LATCH_US_DEFAULT + 1);
      send_poll(now + 5);
      send_edge(1'b1, 32'd20);

      run_phase(CFG_DEFAULT, 0, 0);
      run_phase(zero_w, 56, 0);
      randomize_windows(0);
      run_phase(rand_w, 0, 56);
      run_phase(wide_w, 27, 27);
      run_phase(peak_w, 0, 0);
      run_phase(flip_w, 56, 0);
      randomize_windows(30);
      run_phase(rand_w, 0, 56);
      randomize_windows(0);
      run_phase(rand_w, 27, 27);

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("** nec_ir_pulse_decoder: PASSED **");
      end else begin
         $display("** nec_ir_pulse_decoder: FAILED **");
      end
      $finish;
   end

endmodule
